// ----- rtl/sxts_pkg.sv -----
`timescale 1ns / 1ps
package sxts_pkg;

  // One text byte, or the end-of-text marker.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_marker;
  } in_word_t;

  // One token report.
  typedef struct packed {
    logic [3:0]  tok_kind;
    logic [15:0] tok_start;
    logic [15:0] tok_length;
    logic        text_done;
    logic        last_of_run;
  } out_word_t;

  // Up to two words written into the queue in one cycle.
  typedef struct packed {
    logic      vld0;
    logic      vld1;
    out_word_t w0;
    out_word_t w1;
  } q_push_t;

  // Oldest word waiting in the queue.
  typedef struct packed {
    logic      valid;
    out_word_t word;
  } q_head_t;

endpackage

// ----- rtl/sxts_front.sv -----
`timescale 1ns / 1ps
module sxts_front import sxts_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_word_t in_data,
  output q_push_t  push
);

  localparam int PB = POSITION_BITS;
  localparam logic [PB-1:0] POS_MAX = '1;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_SYMBOL = 2'd1;
  localparam logic [1:0] MODE_STRING = 2'd2;

  localparam logic [1:0] QUOTE_DOUBLE = 2'd0;
  localparam logic [1:0] QUOTE_SINGLE = 2'd1;
  localparam logic [1:0] QUOTE_SLASH  = 2'd2;

  localparam logic [3:0] KIND_LPAREN   = 4'd0;
  localparam logic [3:0] KIND_RPAREN   = 4'd1;
  localparam logic [3:0] KIND_LBRACKET = 4'd2;
  localparam logic [3:0] KIND_RBRACKET = 4'd3;
  localparam logic [3:0] KIND_LANGLE   = 4'd4;
  localparam logic [3:0] KIND_RANGLE   = 4'd5;
  localparam logic [3:0] KIND_SYMBOL   = 4'd6;
  localparam logic [3:0] KIND_NUMBER   = 4'd7;
  localparam logic [3:0] KIND_DOT      = 4'd8;
  localparam logic [3:0] KIND_DQ_STR   = 4'd9;
  localparam logic [3:0] KIND_BROKEN   = 4'd12;

  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_LANGLE    = 8'h3C;
  localparam logic [7:0] CH_RANGLE    = 8'h3E;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;

  function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] v);
    return (v == POS_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_single(input logic [7:0] c);
    return (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_LBRACKET) ||
           (c == CH_RBRACKET) || (c == CH_LANGLE) || (c == CH_RANGLE);
  endfunction

  function automatic logic [3:0] single_code(input logic [7:0] c);
    logic [3:0] k;
    case (c)
      CH_LPAREN:   k = KIND_LPAREN;
      CH_RPAREN:   k = KIND_RPAREN;
      CH_LBRACKET: k = KIND_LBRACKET;
      CH_RBRACKET: k = KIND_RBRACKET;
      CH_LANGLE:   k = KIND_LANGLE;
      default:     k = KIND_RANGLE;
    endcase
    return k;
  endfunction

  function automatic logic is_quote(input logic [7:0] c);
    return (c == CH_DQUOTE) || (c == CH_SQUOTE) || (c == CH_SLASH);
  endfunction

  function automatic logic [1:0] quote_code(input logic [7:0] c);
    logic [1:0] q;
    case (c)
      CH_DQUOTE: q = QUOTE_DOUBLE;
      CH_SQUOTE: q = QUOTE_SINGLE;
      default:   q = QUOTE_SLASH;
    endcase
    return q;
  endfunction

  logic [1:0]    mode_r,   mode_nxt;
  logic [1:0]    quote_r,  quote_nxt;
  logic          esc_r,    esc_nxt;
  logic          digits_r, digits_nxt;
  logic          dot_r,    dot_nxt;
  logic          match_r,  match_nxt;
  logic [PB-1:0] start_r,  start_nxt;
  logic [PB-1:0] len_r,    len_nxt;
  logic [PB-1:0] pos_r,    pos_nxt;

  logic [7:0]    b;
  logic [7:0]    qc;
  logic [3:0]    sym_kind;
  logic [PB-1:0] len_inc;
  logic          p_vld, bb_vld, bb_go;
  out_word_t     p_word, bb_word;

  assign b        = in_data.text_byte;
  assign len_inc  = sat_inc(len_r);
  assign sym_kind = digits_r ? KIND_NUMBER :
                    (dot_r && len_r == PB'(1)) ? KIND_DOT : KIND_SYMBOL;

  always_comb begin
    case (quote_r)
      QUOTE_DOUBLE: qc = CH_DQUOTE;
      QUOTE_SINGLE: qc = CH_SQUOTE;
      default:      qc = CH_SLASH;
    endcase
  end

  always_comb begin
    mode_nxt   = mode_r;
    quote_nxt  = quote_r;
    esc_nxt    = esc_r;
    digits_nxt = digits_r;
    dot_nxt    = dot_r;
    match_nxt  = match_r;
    start_nxt  = start_r;
    len_nxt    = len_r;
    pos_nxt    = pos_r;
    p_vld      = 1'b0;
    p_word     = '0;
    bb_vld     = 1'b0;
    bb_word    = '0;
    bb_go      = 1'b0;
    if (accept) begin
      if (in_data.end_marker) begin
        // flush whatever is open, then restart the text
        p_vld            = 1'b1;
        p_word.text_done = 1'b1;
        case (mode_r)
          MODE_SYMBOL: begin
            p_word.tok_kind   = sym_kind;
            p_word.tok_start  = 16'(start_r);
            p_word.tok_length = 16'(len_r);
          end
          MODE_STRING: begin
            p_word.tok_kind   = (len_r > PB'(1) && match_r) ?
                                KIND_DQ_STR + {2'b00, quote_r} : KIND_BROKEN;
            p_word.tok_start  = 16'(start_r);
            p_word.tok_length = 16'(len_r);
          end
          default: begin
            p_word.tok_kind   = KIND_LPAREN;
            p_word.tok_start  = 16'(pos_r);
            p_word.tok_length = 16'd0;
          end
        endcase
        mode_nxt   = MODE_IDLE;
        quote_nxt  = QUOTE_DOUBLE;
        esc_nxt    = 1'b0;
        digits_nxt = 1'b0;
        dot_nxt    = 1'b0;
        match_nxt  = 1'b0;
        start_nxt  = '0;
        len_nxt    = '0;
        pos_nxt    = '0;
      end else begin
        case (mode_r)
          MODE_STRING: begin
            len_nxt   = len_inc;
            match_nxt = (b == qc);
            if (esc_r) begin
              esc_nxt = 1'b0;
            end else if (b == CH_BACKSLASH && quote_r != QUOTE_SINGLE) begin
              esc_nxt = 1'b1;
            end else if (b == qc) begin
              p_vld             = 1'b1;
              p_word.tok_kind   = KIND_DQ_STR + {2'b00, quote_r};
              p_word.tok_start  = 16'(start_r);
              p_word.tok_length = 16'(len_inc);
              mode_nxt          = MODE_IDLE;
            end
          end
          MODE_SYMBOL: begin
            if (is_space(b) || is_single(b) || is_quote(b)) begin
              p_vld             = 1'b1;
              p_word.tok_kind   = sym_kind;
              p_word.tok_start  = 16'(start_r);
              p_word.tok_length = 16'(len_r);
              mode_nxt          = MODE_IDLE;
              bb_go             = 1'b1;
            end else begin
              len_nxt    = len_inc;
              digits_nxt = digits_r && is_digit(b);
            end
          end
          default: begin
            bb_go = 1'b1;
          end
        endcase
        // start of a new token, or a one-byte token
        if (bb_go && !is_space(b)) begin
          if (is_single(b)) begin
            bb_vld             = 1'b1;
            bb_word.tok_kind   = single_code(b);
            bb_word.tok_start  = 16'(pos_r);
            bb_word.tok_length = 16'd1;
          end else begin
            start_nxt = pos_r;
            len_nxt   = PB'(1);
            if (is_quote(b)) begin
              mode_nxt  = MODE_STRING;
              quote_nxt = quote_code(b);
              esc_nxt   = 1'b0;
              match_nxt = 1'b1;
            end else begin
              mode_nxt   = MODE_SYMBOL;
              digits_nxt = is_digit(b);
              dot_nxt    = (b == CH_DOT);
            end
          end
        end
        pos_nxt = sat_inc(pos_r);
      end
    end
  end

  always_comb begin
    push.vld0           = p_vld | bb_vld;
    push.vld1           = p_vld & bb_vld;
    push.w0             = p_vld ? p_word : bb_word;
    push.w0.last_of_run = ~(p_vld & bb_vld);
    push.w1             = bb_word;
    push.w1.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      quote_r  <= QUOTE_DOUBLE;
      esc_r    <= 1'b0;
      digits_r <= 1'b0;
      dot_r    <= 1'b0;
      match_r  <= 1'b0;
      start_r  <= '0;
      len_r    <= '0;
      pos_r    <= '0;
    end else begin
      mode_r   <= mode_nxt;
      quote_r  <= quote_nxt;
      esc_r    <= esc_nxt;
      digits_r <= digits_nxt;
      dot_r    <= dot_nxt;
      match_r  <= match_nxt;
      start_r  <= start_nxt;
      len_r    <= len_nxt;
      pos_r    <= pos_nxt;
    end
  end

  // A second word only ever follows a flushed symbol, and only it closes the run.
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.vld1 |-> (push.vld0 && !push.w0.last_of_run &&
                   push.w0.tok_kind == KIND_SYMBOL ||
                   push.vld0 && !push.w0.last_of_run &&
                   push.w0.tok_kind == KIND_NUMBER ||
                   push.vld0 && !push.w0.last_of_run &&
                   push.w0.tok_kind == KIND_DOT))
    else $error("second word without a flushed symbol ahead of it");

  // End of text leaves the scanner idle at position zero with no escape pending.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.end_marker |=> (mode_r == MODE_IDLE && !esc_r && pos_r == '0))
    else $error("end of text left scanner state behind");

endmodule

// ----- rtl/sxts_queue.sv -----
`timescale 1ns / 1ps
module sxts_queue import sxts_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst_n,
  input  q_push_t push,
  input  logic    pop,
  output q_head_t head,
  output logic    room2
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  out_word_t     mem_r [DEPTH];
  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [PW-1:0] tail1;

  assign tail1      = ptr_inc(tail_r);
  assign head.valid = (count_r != '0);
  assign head.word  = mem_r[head_r];
  assign room2      = (count_r <= CW'(DEPTH - 2));

  always_comb begin
    head_nxt  = pop ? ptr_inc(head_r) : head_r;
    tail_nxt  = push.vld1 ? ptr_inc(tail1) : (push.vld0 ? tail1 : tail_r);
    count_nxt = count_r + CW'(push.vld0) + CW'(push.vld1) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.vld0) begin
      mem_r[tail_r] <= push.w0;
    end
    if (push.vld1) begin
      mem_r[tail1] <= push.w1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue holds more words than it has entries");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("pop from an empty queue");

endmodule

// ----- rtl/sxts_back.sv -----
`timescale 1ns / 1ps
module sxts_back import sxts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_head_t   head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  logic      valid_r, valid_nxt;
  out_word_t word_r;

  // load a new word whenever the register is empty or being drained
  assign pop       = head.valid && (!valid_r || out_ready);
  assign valid_nxt = pop ? 1'b1 : (valid_r && !out_ready);
  assign out_valid = valid_r;
  assign out_data  = word_r;

  always_ff @(posedge clk) begin
    if (pop) begin
      word_r <= head.word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

// ----- rtl/sexpr_token_scanner.sv -----
`timescale 1ns / 1ps
// S-expression token scanner.
//
// Input channel (in_valid/in_ready/in_data): one word per text byte; a word
// with end_marker set closes the text, flushes any open token and restarts
// positions at zero. Result channel (out_valid/out_ready/out_data): one word
// per token with its kind, start and length; text_done marks the word for
// the end marker and last_of_run marks the final word an input word caused.
//
// Throughput: one input word per cycle while in_ready is high. A byte that
// ends a symbol and is itself a one-byte token yields two result words; the
// output register drains one word per cycle while out_ready is high, so the
// second word leaves behind the first. The queue is written at the edge that
// takes the input, and the output register loads from the queue when it is
// empty or being drained, so each result passes through both in turn.
//
// The front scanner writes up to two words per cycle into a small queue;
// in_ready drops while fewer than two queue entries are free, so a stalled
// receiver backs up into the queue first and then into the sender.
// Reset empties the queue and output register and puts the scanner between
// tokens at position zero.
module sexpr_token_scanner import sxts_pkg::*; #(
  parameter int POSITION_BITS = 16,
  parameter int QUEUE_DEPTH   = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  logic    accept;
  logic    room2;
  logic    pop;
  q_push_t push;
  q_head_t head;

  // take a byte only when the queue can hold both words it might produce
  assign in_ready = room2;
  assign accept   = in_valid && in_ready;

  sxts_front #(
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_data),
    .push    (push)
  );

  sxts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .room2 (room2)
  );

  sxts_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The end-of-text word is always the last one of its run.
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.text_done |-> out_data.last_of_run)
    else $error("text_done word not marked last of run");

  // Nothing is written into the queue unless a byte was taken.
  a_push_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    push.vld0 |-> accept)
    else $error("queue write without an accepted byte");

endmodule

// ----- test/sexpr_token_checker.sv -----
`timescale 1ns / 1ps
module sexpr_token_checker import sxts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_word_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_word_t   out_data,
  output int          fail_count,
  output int          pending,
  output int          words_in,
  output int          words_out,
  output int          texts_closed,
  output logic [15:0] kinds_seen
);

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_SYMBOL, SCAN_STRING} scan_t;
  typedef enum logic [1:0] {Q_DOUBLE, Q_SINGLE, Q_SLASH} quote_t;

  localparam logic [3:0] K_LPAREN = 4'd0;
  localparam logic [3:0] K_RPAREN = 4'd1;
  localparam logic [3:0] K_LBRACK = 4'd2;
  localparam logic [3:0] K_RBRACK = 4'd3;
  localparam logic [3:0] K_LANGLE = 4'd4;
  localparam logic [3:0] K_RANGLE = 4'd5;
  localparam logic [3:0] K_SYMBOL = 4'd6;
  localparam logic [3:0] K_NUMBER = 4'd7;
  localparam logic [3:0] K_DOT    = 4'd8;
  localparam logic [3:0] K_DQ_STR = 4'd9;
  localparam logic [3:0] K_BROKEN = 4'd12;

  localparam logic [15:0] POS_MAX     = 16'hFFFF;
  localparam int          MAX_REPORTS = 40;

  // Scanner image
  scan_t       mode;
  quote_t      quote;
  logic        esc;
  logic        digits;
  logic        dot_first;
  logic        last_quote;
  logic [15:0] tok_from;
  logic [15:0] tok_len;
  logic [15:0] pos;

  out_word_t token_q[$];
  out_word_t batch[2];
  int        nb;

  function automatic logic [15:0] sat_inc(logic [15:0] v);
    return (v == POS_MAX) ? v : v + 16'd1;
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic int bracket_kind(logic [7:0] b);
    case (b)
      "(": return K_LPAREN;
      ")": return K_RPAREN;
      "[": return K_LBRACK;
      "]": return K_RBRACK;
      "<": return K_LANGLE;
      ">": return K_RANGLE;
      default: return -1;
    endcase
  endfunction

  function automatic int quote_of(logic [7:0] b);
    case (b)
      "\"": return Q_DOUBLE;
      "'": return Q_SINGLE;
      "/": return Q_SLASH;
      default: return -1;
    endcase
  endfunction

  function automatic logic [7:0] quote_byte(quote_t q);
    case (q)
      Q_DOUBLE: return "\"";
      Q_SINGLE: return "'";
      default: return "/";
    endcase
  endfunction

  function automatic logic [3:0] symbol_kind();
    if (digits) return K_NUMBER;
    if (dot_first && tok_len == 16'd1) return K_DOT;
    return K_SYMBOL;
  endfunction

  function automatic void emit(logic [3:0] kind, logic [15:0] from, logic [15:0] len,
                               logic done);
    batch[nb].tok_kind    = kind;
    batch[nb].tok_start   = from;
    batch[nb].tok_length  = len;
    batch[nb].text_done   = done;
    batch[nb].last_of_run = 1'b0;
    nb++;
  endfunction

  function automatic void clear_scan();
    mode       = SCAN_IDLE;
    quote      = Q_DOUBLE;
    esc        = 1'b0;
    digits     = 1'b0;
    dot_first  = 1'b0;
    last_quote = 1'b0;
    tok_from   = '0;
    tok_len    = '0;
    pos        = '0;
  endfunction

  // Byte seen between tokens: skip space, report a bracket, or open a run.
  function automatic void open_token(logic [7:0] b);
    int k;
    int q;
    k = bracket_kind(b);
    q = quote_of(b);
    if (is_space(b)) return;
    if (k >= 0) begin
      emit(4'(k), pos, 16'd1, 1'b0);
      return;
    end
    tok_from = pos;
    tok_len  = 16'd1;
    if (q >= 0) begin
      mode       = SCAN_STRING;
      quote      = quote_t'(q);
      esc        = 1'b0;
      last_quote = 1'b1;
    end else begin
      mode      = SCAN_SYMBOL;
      digits    = is_digit(b);
      dot_first = (b == ".");
    end
  endfunction

  function automatic void scan_word(in_word_t w);
    logic [7:0] b;
    b  = w.text_byte;
    nb = 0;
    if (w.end_marker) begin
      case (mode)
        SCAN_SYMBOL: emit(symbol_kind(), tok_from, tok_len, 1'b1);
        SCAN_STRING:
          emit((tok_len > 16'd1 && last_quote) ? K_DQ_STR + 4'(quote) : K_BROKEN,
               tok_from, tok_len, 1'b1);
        default: emit(K_LPAREN, pos, 16'd0, 1'b1);
      endcase
      texts_closed++;
      clear_scan();
    end else begin
      case (mode)
        SCAN_STRING: begin
          tok_len    = sat_inc(tok_len);
          last_quote = (b == quote_byte(quote));
          if (esc) begin
            esc = 1'b0;
          end else if (b == "\\" && quote != Q_SINGLE) begin
            esc = 1'b1;
          end else if (b == quote_byte(quote)) begin
            emit(K_DQ_STR + 4'(quote), tok_from, tok_len, 1'b0);
            mode = SCAN_IDLE;
          end
        end
        SCAN_SYMBOL: begin
          if (is_space(b) || bracket_kind(b) >= 0 || quote_of(b) >= 0) begin
            emit(symbol_kind(), tok_from, tok_len, 1'b0);
            mode = SCAN_IDLE;
            open_token(b);
          end else begin
            tok_len = sat_inc(tok_len);
            digits  = digits && is_digit(b);
          end
        end
        default: open_token(b);
      endcase
      pos = sat_inc(pos);
    end
    if (nb > 0) batch[nb - 1].last_of_run = 1'b1;
    for (int i = 0; i < nb; i++) token_q.push_back(batch[i]);
  endfunction

  task automatic report(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic cmp_field(string name, int want, int got);
    if (want != got)
      report($sformatf("word %0d %s expected %0d got %0d", words_out, name, want, got));
  endtask

  task automatic check_word(out_word_t got);
    out_word_t want;
    if (token_q.size() == 0) begin
      report($sformatf("word %0d arrived with none pending (kind %0d start %0d len %0d)",
                       words_out, got.tok_kind, got.tok_start, got.tok_length));
      return;
    end
    want = token_q.pop_front();
    kinds_seen[got.tok_kind] = 1'b1;
    cmp_field("tok_kind", want.tok_kind, got.tok_kind);
    cmp_field("tok_start", want.tok_start, got.tok_start);
    cmp_field("tok_length", want.tok_length, got.tok_length);
    cmp_field("text_done", want.text_done, got.text_done);
    cmp_field("last_of_run", want.last_of_run, got.last_of_run);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_scan();
      token_q.delete();
      fail_count   = 0;
      pending      = 0;
      words_in     = 0;
      words_out    = 0;
      texts_closed = 0;
      kinds_seen   = '0;
    end else begin
      // Check the result side first: nothing taken this edge can already be out.
      if (out_valid && out_ready) begin
        words_out++;
        check_word(out_data);
      end
      if (in_valid && in_ready) begin
        words_in++;
        scan_word(in_data);
      end
      pending = token_q.size();
    end
  end

endmodule

// ----- test/sexpr_token_scanner_tb.sv -----
`timescale 1ns / 1ps
module sexpr_token_scanner_tb;
  import sxts_pkg::*;

  localparam int RANDOM_WORDS = 320;    // random words to offer after the directed part
  localparam int LONG_RUN     = 60;     // symbol bytes sent with no idling on either side
  localparam int HOLD_CYCLES  = 150;    // receiver back-pressure stretch
  localparam int STALL_LIMIT  = 1000;   // cycles with no word moved before giving up
  localparam int IDLE_PCT     = 17;     // chance per cycle that a side idles

  logic      clk      = 1'b0;
  logic      rst_n    = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data  = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  // Checker outputs
  int          fail_count;
  int          pending;
  int          words_in;
  int          words_out;
  int          texts_closed;
  logic [15:0] kinds_seen;

  logic steady     = 1'b0;  // both sides run flat out, no idle cycles
  logic hold_req   = 1'b0;  // ask the receiver for one long hold-off
  int   sent       = 0;
  int   dry_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  sexpr_token_scanner uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  sexpr_token_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .words_in    (words_in),
    .words_out   (words_out),
    .texts_closed(texts_closed),
    .kinds_seen  (kinds_seen)
  );

  // Separator bytes end a symbol: whitespace, brackets and quote openers.
  function automatic logic is_sep(logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D) ||
           (b == "(") || (b == ")") || (b == "[") || (b == "]") ||
           (b == "<") || (b == ">") || (b == "\"") || (b == "'") || (b == "/");
  endfunction

  // Any byte that extends a symbol, zero and high bytes included.
  function automatic logic [7:0] symbol_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (is_sep(b));
    return b;
  endfunction

  function automatic logic [7:0] pick_of(string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  // Offer one word: maybe idle a few cycles first, then hold valid and the
  // payload steady until the edge that takes it, and return at the next falling edge.
  task automatic send(in_word_t w);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_byte(logic [7:0] b);
    in_word_t w;
    w.text_byte  = b;
    w.end_marker = 1'b0;
    send(w);
  endtask

  // End of text; the byte lane carries junk the block must ignore.
  task automatic send_end();
    in_word_t w;
    w.text_byte  = 8'($urandom_range(255));
    w.end_marker = 1'b1;
    send(w);
  endtask

  // Mostly well-formed tokens with random content; some noise, some
  // strings left open, and the odd end marker to close a text anywhere.
  task automatic send_token();
    int         pick;
    int         n;
    logic [7:0] b;
    logic [7:0] opener;
    pick = $urandom_range(99);
    if (pick < 14) begin
      send_byte(pick_of("()[]<>"));
    end else if (pick < 26) begin
      // Whitespace run; 0x0E stands in for a plain space.
      n = $urandom_range(3, 1);
      repeat (n) begin
        b = 8'($urandom_range(14, 9));
        send_byte((b == 8'h0E) ? 8'h20 : b);
      end
    end else if (pick < 38) begin
      n = $urandom_range(4, 1);
      repeat (n) send_byte(8'("0" + $urandom_range(9)));
    end else if (pick < 43) begin
      send_byte(".");
    end else if (pick < 58) begin
      n = $urandom_range(6, 1);
      if ($urandom_range(4) == 0) send_byte(".");
      repeat (n) send_byte(symbol_byte());
    end else if (pick < 82) begin
      opener = pick_of("\"'/");
      send_byte(opener);
      n = $urandom_range(5);
      repeat (n) begin
        pick = $urandom_range(99);
        if (pick < 20) begin
          send_byte("\\");
          send_byte(8'($urandom_range(255)));
        end else if (pick < 35) begin
          send_byte(8'($urandom_range(255)));
        end else begin
          send_byte(8'("a" + $urandom_range(25)));
        end
      end
      // Leave some strings open so later bytes or an end marker land inside.
      if ($urandom_range(99) < 85) send_byte(opener);
    end else if (pick < 92) begin
      send_byte(8'($urandom_range(255)));
    end else begin
      send_end();
    end
  endtask

  // Receiver: random ready, flat out while steady, and one long hold-off
  // counted here so the block's queue fills and in_ready drops.
  initial begin : receiver
    int   hold_left;
    logic hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_left  = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: give up when no word moves on either channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        dry_cycles <= 0;
      end else if (dry_cycles + 1 >= STALL_LIMIT) begin
        $display("stalled: no word moved for %0d cycles, %0d results pending",
                 STALL_LIMIT, pending);
        $display("FAILURE");
        $finish;
      end else begin
        dry_cycles <= dry_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int base;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // End of text with nothing open: empty result at position zero.
    send_end();
    // Symbol holding a zero and a high byte, cut by a bracket: two words.
    send_byte("a");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte("(");
    // Remaining brackets.
    send_byte(")");
    send_byte("[");
    send_byte("]");
    send_byte("<");
    send_byte(">");
    // Number ended by whitespace.
    send_byte("1");
    send_byte("2");
    send_byte(" ");
    // Lone dot cut by a quote; single-quoted string treats backslash as plain.
    send_byte(".");
    send_byte("'");
    send_byte("\\");
    send_byte("'");
    // Regexp whose last byte is an escaped slash, closed by end of text: typed.
    send_byte("/");
    send_byte("\\");
    send_byte("/");
    send_end();
    // Escape pending at end of text: string is broken, escape dropped.
    send_byte("\"");
    send_byte("\\");
    send_end();

    // Long symbol with no idling on either side, then brackets right behind it.
    steady <= 1'b1;
    repeat (LONG_RUN) send_byte(symbol_byte());
    send_byte("(");
    send_byte(")");
    send_end();
    steady <= 1'b0;

    // Random text; the receiver stalls hard right at the start.
    hold_req <= 1'b1;
    base = sent;
    while (sent - base < RANDOM_WORDS) send_token();
    send_end();
    in_valid <= 1'b0;

    // Drain, then give stray words a few cycles to show up.
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("scanned %0d input words into %0d result words over %0d texts",
             words_in, words_out, texts_closed);
    $display("token kinds seen: %0d of 13; one idle-free stretch, one long receiver stall",
             $countones(kinds_seen));
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
